// ----- rtl/protobuf_field_extractor_top_defines.svh -----
// assertion macros for the field extractor
`ifndef PROTOBUF_FIELD_EXTRACTOR_TOP_DEFINES_SVH
`define PROTOBUF_FIELD_EXTRACTOR_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pfe_pkg.sv -----
package pfe_pkg;

	localparam int LEN_BITS = 16;
	localparam logic [32:0] LEN_CAP = (33'd1 << LEN_BITS) - 33'd1;

	localparam logic [2:0] PH_TAG    = 3'd0;
	localparam logic [2:0] PH_VARINT = 3'd1;
	localparam logic [2:0] PH_LENGTH = 3'd2;
	localparam logic [2:0] PH_SKIP   = 3'd3;
	localparam logic [2:0] PH_STRING = 3'd4;
	localparam logic [2:0] PH_FIXED  = 3'd5;

	localparam logic [2:0] ST_BYTE      = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_VALUE     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND  = 3'd3;
	localparam logic [2:0] ST_MALFORMED = 3'd4;

	localparam logic [1:0] KIND_STRING  = 2'd0;
	localparam logic [1:0] KIND_FIXED32 = 2'd1;
	localparam logic [1:0] KIND_BOOL    = 2'd2;

	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_LEN     = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	typedef struct packed {
		logic [7:0]  byte_in;
		logic        first;
		logic [15:0] msg_len;
		logic [4:0]  wanted_field;
		logic [1:0]  wanted_kind;
	} pfe_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] out_data;
		logic        out_last;
	} pfe_result_t;

	function automatic pfe_result_t mk_res(input logic [2:0] status, input logic [31:0] data,
		input logic last);
		pfe_result_t r;
		r.status   = status;
		r.out_data = data;
		r.out_last = last;
		return r;
	endfunction

	// length too large for the cap or for the bytes left
	function automatic logic len_bad(input logic [31:0] sl, input logic [15:0] rem);
		return (33'(sl) > LEN_CAP) || (sl > 32'(rem));
	endfunction

endpackage

// ----- rtl/pfe_parser.sv -----
module pfe_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  pfe_pkg::pfe_item_t  item,
	input  logic                fire,
	output pfe_pkg::pfe_result_t res,
	output logic                res_valid
);
	import pfe_pkg::*;

	logic [2:0]  phase_q;
	logic [15:0] pos_q;
	logic [15:0] brem_q;
	logic [31:0] acc_q;
	logic [5:0]  shift_q;
	logic        fm_q;
	logic        done_q;

	logic [2:0]  e_phase;
	logic [15:0] e_pos;
	logic [15:0] e_brem;
	logic [31:0] e_acc;
	logic [5:0]  e_shift;
	logic        e_fm;
	logic        e_done;

	logic [2:0]  n_phase;
	logic [15:0] n_pos;
	logic [15:0] n_brem;
	logic [31:0] n_acc;
	logic [5:0]  n_shift;
	logic        n_fm;
	logic        n_done;

	logic [15:0] pos_inc;
	logic [15:0] rem;
	logic [41:0] vt;
	logic [31:0] vacc;
	logic [5:0]  vshift;
	logic        vend;
	logic        fm_new;
	logic [15:0] bdec;
	logic [31:0] fx_acc;
	logic [5:0]  fx_shift;

	// a first transaction starts from the reset state
	assign e_phase = item.first ? PH_TAG : phase_q;
	assign e_pos   = item.first ? 16'd0 : pos_q;
	assign e_brem  = item.first ? 16'd0 : brem_q;
	assign e_acc   = item.first ? 32'd0 : acc_q;
	assign e_shift = item.first ? 6'd0 : shift_q;
	assign e_fm    = item.first ? 1'b0 : fm_q;
	assign e_done  = item.first ? 1'b0 : done_q;

	assign pos_inc = e_pos + 16'd1;
	assign rem     = item.msg_len - pos_inc;

	// varint byte, saturating beyond 32 bits
	assign vt     = 42'(item.byte_in[6:0]) << e_shift;
	assign vacc   = (|vt[41:32]) ? 32'hFFFF_FFFF : (e_acc | vt[31:0]);
	assign vshift = (e_shift < 6'd32) ? e_shift + 6'd7 : e_shift;
	assign vend   = !item.byte_in[7];

	assign fm_new   = item.byte_in[7:3] == item.wanted_field;
	assign bdec     = (e_brem != 16'd0) ? e_brem - 16'd1 : e_brem;
	assign fx_acc   = e_acc | (32'(item.byte_in) << {e_shift[1:0], 3'b000});
	assign fx_shift = e_shift + 6'd1;

	always_comb begin
		n_phase   = e_phase;
		n_pos     = e_pos;
		n_brem    = e_brem;
		n_acc     = e_acc;
		n_shift   = e_shift;
		n_fm      = e_fm;
		n_done    = e_done;
		res_valid = 1'b0;
		res       = mk_res(ST_NOTFOUND, 32'd0, 1'b1);

		if (item.first && item.msg_len == 16'd0) begin
			res_valid = 1'b1;
		end else if (!e_done && e_pos < item.msg_len) begin
			n_pos = pos_inc;
			case (e_phase)
				PH_TAG: begin
					n_fm    = fm_new;
					n_acc   = 32'd0;
					n_shift = 6'd0;
					case (item.byte_in[2:0])
						WT_VARINT: n_phase = PH_VARINT;
						WT_LEN:    n_phase = PH_LENGTH;
						WT_FIXED32: begin
							if (rem < 16'd4) begin
								res_valid = 1'b1;
								res       = mk_res(ST_MALFORMED, 32'd0, 1'b1);
							end else if (item.wanted_kind == KIND_FIXED32 && fm_new) begin
								n_phase = PH_FIXED;
							end else begin
								n_phase = PH_SKIP;
								n_brem  = 16'd4;
							end
						end
						default: begin
							res_valid = 1'b1;
							res       = mk_res(ST_MALFORMED, 32'd0, 1'b1);
						end
					endcase
				end
				PH_VARINT: begin
					n_acc   = vacc;
					n_shift = vshift;
					if (vend) begin
						if (item.wanted_kind == KIND_BOOL && e_fm) begin
							res_valid = 1'b1;
							res = mk_res(ST_VALUE, {31'd0, vacc != 32'd0}, 1'b1);
						end else begin
							n_phase = PH_TAG;
						end
					end
				end
				PH_LENGTH: begin
					n_acc   = vacc;
					n_shift = vshift;
					if (vend) begin
						n_brem = vacc[15:0];
						if (len_bad(vacc, rem)) begin
							res_valid = 1'b1;
							res       = mk_res(ST_MALFORMED, 32'd0, 1'b1);
						end else if (item.wanted_kind == KIND_STRING && e_fm) begin
							if (vacc == 32'd0) begin
								res_valid = 1'b1;
								res       = mk_res(ST_EMPTY, 32'd0, 1'b1);
							end else begin
								n_phase = PH_STRING;
							end
						end else begin
							n_phase = (vacc == 32'd0) ? PH_TAG : PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					n_brem = bdec;
					if (bdec == 16'd0) begin
						n_phase = PH_TAG;
					end
				end
				PH_STRING: begin
					n_brem    = bdec;
					res_valid = 1'b1;
					res       = mk_res(ST_BYTE, 32'(item.byte_in), bdec == 16'd0);
				end
				PH_FIXED: begin
					n_acc   = fx_acc;
					n_shift = fx_shift;
					if (fx_shift >= 6'd4) begin
						res_valid = 1'b1;
						res       = mk_res(ST_VALUE, fx_acc, 1'b1);
					end
				end
				default: n_phase = PH_TAG;
			endcase

			// message end without a final result
			if (!res_valid && rem == 16'd0) begin
				res_valid = 1'b1;
				if (n_phase == PH_VARINT && item.wanted_kind == KIND_BOOL && n_fm) begin
					res = mk_res(ST_VALUE, {31'd0, n_acc != 32'd0}, 1'b1);
				end else if (n_phase == PH_LENGTH && len_bad(n_acc, 16'd0)) begin
					res = mk_res(ST_MALFORMED, 32'd0, 1'b1);
				end else if (n_phase == PH_LENGTH && item.wanted_kind == KIND_STRING
					&& n_fm) begin
					res = mk_res(ST_EMPTY, 32'd0, 1'b1);
				end else begin
					res = mk_res(ST_NOTFOUND, 32'd0, 1'b1);
				end
			end
		end

		if (res_valid && res.out_last) begin
			n_done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			pos_q   <= 16'd0;
			brem_q  <= 16'd0;
			acc_q   <= 32'd0;
			shift_q <= 6'd0;
			fm_q    <= 1'b0;
			done_q  <= 1'b1;
		end else if (fire) begin
			phase_q <= n_phase;
			pos_q   <= n_pos;
			brem_q  <= n_brem;
			acc_q   <= n_acc;
			shift_q <= n_shift;
			fm_q    <= n_fm;
			done_q  <= n_done;
		end
	end

endmodule

// ----- rtl/protobuf_field_extractor_top.sv -----
// Protobuf field extractor: takes one message byte per transaction and reports the first
// field with the wanted number and kind, as string bytes, a fixed32 value, a boolean, an
// empty string, or not_found / malformed, with out_last on the final result of each
// message. A byte is accepted every cycle while the result side keeps up; each byte goes
// from an input register through one pass of parse logic into the result register,
// which drives the output. A stalled result holds the input register, which still takes
// one more byte while it is empty, and then the input stalls until the result is taken.
`include "protobuf_field_extractor_top_defines.svh"

module protobuf_field_extractor_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pfe_pkg::pfe_item_t   item,
	input  logic                 item_valid,
	output logic                 item_stall,
	output pfe_pkg::pfe_result_t result,
	output logic                 result_valid,
	input  logic                 result_stall
);
	import pfe_pkg::*;

	pfe_item_t   item_s1;
	logic        valid_s1;
	logic        out_free;
	logic        adv;
	pfe_result_t res;
	logic        res_valid;
	pfe_result_t result_q;
	logic        result_valid_q;

	assign out_free   = !result_valid_q || !result_stall;
	assign adv        = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	pfe_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_s1),
		.fire      (adv),
		.res       (res),
		.res_valid (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= adv && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			result_q <= res;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	`PFE_ASSERT_NEXT(a_res_loaded, adv && res_valid, result_valid_q, "parser result dropped")
	`PFE_ASSERT_NOW(a_last_non_byte, result_valid_q && result_q.status != ST_BYTE,
		result_q.out_last, "final status without out_last")
	`PFE_ASSERT_NOW(a_zero_data, result_valid_q && (result_q.status == ST_EMPTY
		|| result_q.status == ST_NOTFOUND || result_q.status == ST_MALFORMED),
		result_q.out_data == 32'd0, "nonzero data on a status without value")

endmodule
